@@ sv/rds_pkg.sv @@
`timescale 1ns / 1ps
package rds_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int FRAC_BITS = 16;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int DIM_W     = 17;
   localparam int MIN_DIM   = 5;

   localparam logic [63:0] CAP62 = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

   typedef enum logic [1:0] {
      REG_ENABLE = 2'd0,
      REG_RATE   = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_SQX, ST_SQY,
      ST_LX0, ST_LY0, ST_RT0,
      ST_LX1, ST_LY1, ST_RT1,
      ST_LX2, ST_LY2, ST_RT2,
      ST_JX, ST_JY, ST_JJ, ST_JR
   } step_type;

   typedef struct packed {
      logic [31:0] x1;
      logic [31:0] x0;
      logic [31:0] y1;
      logic [31:0] y0;
      logic [31:0] z1;
      logic [31:0] z0;
      logic [31:0] e;
      logic [31:0] dx;
      logic [31:0] dy;
   } line_word_type;

   localparam int LINE_BITS = $bits(line_word_type);

   typedef struct packed {
      logic        start;
      wide_type    a;
      logic [63:0] b;
      logic        sh_plus1;
   } mul_req_type;

   function automatic wide_type ext64(input logic [31:0] v);
      ext64 = {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] sat32(input wide_type v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

@@ sv/resistive_diffusion_stencil.sv @@
`timescale 1ns / 1ps
// Resistive diffusion stencil over a raster stream of grid cells.
// Feed every cell of a frame, ghost border included, on the req_ channel;
// a beat moves when req_valid is high and req_stall low. The block returns
// one rsp_ beat for each interior cell, one row and one column behind the
// input, with rsp_last_cell marking the final interior cell of the frame.
// Line history sits in one memory of MAX_WIDTH words holding two rows of
// each field component and one row of energy and spacings; the memory is
// read when a beat is accepted and written back the next cycle.
// Every cell passes S_IDLE and S_UPD; a border cell then goes back to
// S_IDLE and an interior cell goes on to S_DONE, an enabled one by way of
// S_CALC, where fifteen products run one after the other through a single
// 32x32 multiplier, four partial products each.
// The result register frees the input side: the next beat is taken while a
// result waits on rsp_stall. req_stall is high while a cell is in work and
// stays high while a second result is ready before the first is taken.
// csr_ registers are to be written only while the block is idle, which the
// block itself does not enforce; csr_ready is always high. Reset clears
// the window, counters, enable and rate but not the line memory, which
// the first two rows of a frame fill; width and height reset to 1024.
module resistive_diffusion_stencil
   import rds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  word_type    req_field_x,
   input  word_type    req_field_y,
   input  word_type    req_field_z,
   input  word_type    req_energy,
   input  logic [31:0] req_inv_dx,
   input  logic [31:0] req_inv_dy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output word_type    rsp_new_field_x,
   output word_type    rsp_new_field_y,
   output word_type    rsp_new_field_z,
   output word_type    rsp_new_energy,
   output logic        rsp_last_cell,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_UPD  = 4'b0010,
      S_CALC = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic        enable_ff;
   logic [31:0] rate_ff;
   logic [10:0] gw_ff;
   logic [15:0] gh_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      row_ff, row_in;

   word_type    in_x_ff, in_y_ff, in_z_ff, in_e_ff;
   logic [31:0] in_dx_ff, in_dy_ff;

   word_type    win_ff [3][9];
   word_type    win_in [3][9];
   word_type    ctr_e_ff, ctr_dx_ff, ctr_dy_ff;
   word_type    cur_e_ff;
   logic [31:0] cur_dx_ff, cur_dy_ff;
   logic        last_ff;

   step_type    step_ff;
   logic        go_ff;
   wide_type    acc_ff;
   logic [63:0] sqx_ff, sqy_ff;
   word_type    res_ff [4];

   logic        rsp_valid_ff, rsp_last_ff;
   word_type    rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_e_ff;

   line_word_type rd_word, wr_word;
   logic [LINE_BITS-1:0] rd_bits;
   logic          accept;

   logic [DIM_W-1:0] eff_w, eff_h, c_ext, r_ext, c_next, r_next;
   logic             emit, is_last;

   mul_req_type mul_req;
   logic        mul_done;
   wide_type    mul_res;
   wide_type    hdiff [3];
   wide_type    vdiff [3];
   wide_type    acc_abs;
   logic        out_free;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rate_ff   <= 32'd0;
         gw_ff     <= 11'd1024;
         gh_ff     <= 16'd1024;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ENABLE: enable_ff <= csr_data[0];
            REG_RATE:   rate_ff   <= csr_data;
            REG_WIDTH:  gw_ff     <= csr_data[10:0];
            REG_HEIGHT: gh_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   rds_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (state_ff == S_UPD),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_bits)
   );

   assign rd_word = line_word_type'(rd_bits);

   always_comb begin
      wr_word    = rd_word;
      wr_word.x1 = rd_word.x0;
      wr_word.x0 = in_x_ff;
      wr_word.y1 = rd_word.y0;
      wr_word.y0 = in_y_ff;
      wr_word.z1 = rd_word.z0;
      wr_word.z0 = in_z_ff;
      wr_word.e  = in_e_ff;
      wr_word.dx = in_dx_ff;
      wr_word.dy = in_dy_ff;
   end

   always_comb begin
      eff_w = DIM_W'(gw_ff);
      if (eff_w < DIM_W'(MIN_DIM)) begin
         eff_w = DIM_W'(MIN_DIM);
      end else if (eff_w > DIM_W'(MAX_WIDTH)) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end
      eff_h = DIM_W'(gh_ff);
      if (eff_h < DIM_W'(MIN_DIM)) begin
         eff_h = DIM_W'(MIN_DIM);
      end
      c_ext   = DIM_W'(col_ff);
      r_ext   = DIM_W'(row_ff);
      c_next  = c_ext + DIM_W'(1);
      r_next  = r_ext + DIM_W'(1);
      emit    = (r_ext >= DIM_W'(3)) && (r_ext + DIM_W'(2) <= eff_h) &&
                (c_ext >= DIM_W'(3)) && (c_ext + DIM_W'(2) <= eff_w);
      is_last = (r_ext + DIM_W'(2) == eff_h) && (c_ext + DIM_W'(2) == eff_w);
      col_in  = col_ff;
      row_in  = row_ff;
      if (c_next >= eff_w) begin
         col_in = '0;
         row_in = (r_next >= eff_h) ? 16'd0 : r_next[15:0];
      end else begin
         col_in = c_next[COL_W-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            win_in[k][j*3]   = win_ff[k][j*3+1];
            win_in[k][j*3+1] = win_ff[k][j*3+2];
         end
      end
      win_in[0][2] = rd_word.x1;
      win_in[0][5] = rd_word.x0;
      win_in[0][8] = in_x_ff;
      win_in[1][2] = rd_word.y1;
      win_in[1][5] = rd_word.y0;
      win_in[1][8] = in_y_ff;
      win_in[2][2] = rd_word.z1;
      win_in[2][5] = rd_word.z0;
      win_in[2][8] = in_z_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hdiff[k] = ext64(win_ff[k][5]) - (ext64(win_ff[k][4]) <<< 1) + ext64(win_ff[k][3]);
         vdiff[k] = ext64(win_ff[k][7]) - (ext64(win_ff[k][4]) <<< 1) + ext64(win_ff[k][1]);
      end
      acc_abs = acc_ff[63] ? -acc_ff : acc_ff;
   end

   always_comb begin
      mul_req.start    = go_ff && (state_ff == S_CALC);
      mul_req.sh_plus1 = 1'b0;
      mul_req.a        = acc_ff;
      mul_req.b        = {32'd0, rate_ff};
      case (step_ff)
         ST_SQX: begin
            mul_req.a = wide_type'({32'd0, cur_dx_ff});
            mul_req.b = {32'd0, cur_dx_ff};
         end
         ST_SQY: begin
            mul_req.a = wide_type'({32'd0, cur_dy_ff});
            mul_req.b = {32'd0, cur_dy_ff};
         end
         ST_LX0: begin
            mul_req.a = hdiff[0];
            mul_req.b = sqx_ff;
         end
         ST_LY0: begin
            mul_req.a = vdiff[0];
            mul_req.b = sqy_ff;
         end
         ST_LX1: begin
            mul_req.a = hdiff[1];
            mul_req.b = sqx_ff;
         end
         ST_LY1: begin
            mul_req.a = vdiff[1];
            mul_req.b = sqy_ff;
         end
         ST_LX2: begin
            mul_req.a = hdiff[2];
            mul_req.b = sqx_ff;
         end
         ST_LY2: begin
            mul_req.a = vdiff[2];
            mul_req.b = sqy_ff;
         end
         ST_JX: begin
            mul_req.a        = ext64(win_ff[1][5]) - ext64(win_ff[1][3]);
            mul_req.b        = {32'd0, cur_dx_ff};
            mul_req.sh_plus1 = 1'b1;
         end
         ST_JY: begin
            mul_req.a        = ext64(win_ff[0][7]) - ext64(win_ff[0][1]);
            mul_req.b        = {32'd0, cur_dy_ff};
            mul_req.sh_plus1 = 1'b1;
         end
         ST_JJ: begin
            mul_req.b = acc_abs;
         end
         default: ;
      endcase
   end

   rds_pmul u_pmul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (!emit) begin
               state_in = S_IDLE;
            end else if (enable_ff) begin
               state_in = S_CALC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CALC: begin
            if (mul_done && (step_ff == ST_JR)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         ctr_e_ff     <= '0;
         ctr_dx_ff    <= '0;
         ctr_dy_ff    <= '0;
         go_ff        <= 1'b0;
         step_ff      <= ST_SQX;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 9; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_UPD) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            ctr_e_ff  <= rd_word.e;
            ctr_dx_ff <= rd_word.dx;
            ctr_dy_ff <= rd_word.dy;
            win_ff    <= win_in;
            step_ff   <= ST_SQX;
            go_ff     <= 1'b1;
         end else if (state_ff == S_CALC) begin
            if (mul_req.start) begin
               go_ff <= 1'b0;
            end else if (mul_done && (step_ff != ST_JR)) begin
               step_ff <= step_type'(step_ff + 4'd1);
               go_ff   <= 1'b1;
            end
         end
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff  <= req_field_x;
         in_y_ff  <= req_field_y;
         in_z_ff  <= req_field_z;
         in_e_ff  <= req_energy;
         in_dx_ff <= req_inv_dx;
         in_dy_ff <= req_inv_dy;
      end
      if (state_ff == S_UPD) begin
         cur_e_ff  <= ctr_e_ff;
         cur_dx_ff <= ctr_dx_ff;
         cur_dy_ff <= ctr_dy_ff;
         last_ff   <= is_last;
      end
      if ((state_ff == S_CALC) && mul_done) begin
         case (step_ff)
            ST_SQX: sqx_ff <= mul_res;
            ST_SQY: sqy_ff <= mul_res;
            ST_LX0, ST_LX1, ST_LX2, ST_JX, ST_JJ: acc_ff <= mul_res;
            ST_LY0, ST_LY1, ST_LY2: acc_ff <= acc_ff + mul_res;
            ST_JY:  acc_ff <= acc_ff - mul_res;
            ST_RT0: res_ff[0] <= sat32(ext64(win_ff[0][4]) + mul_res);
            ST_RT1: res_ff[1] <= sat32(ext64(win_ff[1][4]) + mul_res);
            ST_RT2: res_ff[2] <= sat32(ext64(win_ff[2][4]) + mul_res);
            ST_JR:  res_ff[3] <= sat32(ext64(cur_e_ff) + mul_res);
            default: ;
         endcase
      end
      if ((state_ff == S_DONE) && out_free) begin
         rsp_x_ff    <= enable_ff ? res_ff[0] : win_ff[0][4];
         rsp_y_ff    <= enable_ff ? res_ff[1] : win_ff[1][4];
         rsp_z_ff    <= enable_ff ? res_ff[2] : win_ff[2][4];
         rsp_e_ff    <= enable_ff ? res_ff[3] : cur_e_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_field_x = rsp_x_ff;
   assign rsp_new_field_y = rsp_y_ff;
   assign rsp_new_field_z = rsp_z_ff;
   assign rsp_new_energy  = rsp_e_ff;
   assign rsp_last_cell   = rsp_last_ff;

endmodule

@@ sv/rds_ram.sv @@
`timescale 1ns / 1ps
module rds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ sv/rds_pmul.sv @@
`timescale 1ns / 1ps
module rds_pmul
   import rds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output logic        done,
   output wide_type    result
);

   logic [63:0]  ma_ff, mb_ff;
   logic         neg_ff, sh1_ff;
   logic [127:0] acc_ff;
   logic [1:0]   cnt_ff;
   logic         busy_ff, done_ff;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_sh, shifted;
   logic [63:0]  mag;

   assign a_part = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_part = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp     = a_part * b_part;

   always_comb begin
      case (cnt_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 2'd3);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         ma_ff  <= req.a[63] ? 64'(-req.a) : req.a;
         mb_ff  <= req.b;
         neg_ff <= req.a[63];
         sh1_ff <= req.sh_plus1;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign shifted = sh1_ff ? (acc_ff >> (FRAC_BITS + 1)) : (acc_ff >> FRAC_BITS);
   assign mag     = (|shifted[127:62]) ? CAP62 : shifted[63:0];
   assign result  = neg_ff ? -wide_type'(mag) : wide_type'(mag);
   assign done    = done_ff;

endmodule
